// ===== rtl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

   localparam logic [31:0] BASE_RESET = 32'h2000_1000;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_ZERO    = 2'd1,
      STAT_NOSPACE = 2'd2,
      STAT_BADADDR = 2'd3
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b000_0001,
      ST_CLEAR   = 7'b000_0010,
      ST_DIVIDE  = 7'b000_0100,
      ST_PRIME   = 7'b000_1000,
      ST_SCAN    = 7'b001_0000,
      ST_MARK    = 7'b010_0000,
      ST_RELEASE = 7'b100_0000
   } state_type;

endpackage

// ===== rtl/first_fit_block_allocator.sv =====
// Top level: first-fit bitmap allocator with a bit-serial map sequencer.
//
// Requests enter on req_* when start is high and busy is low; each request
// gives exactly one result, shown on rsp_* for one cycle with rsp_valid high.
// The receiver has no hold-off, so results are never stalled.
// csr_base_address is written when csr_valid and csr_ready are high; it moves
// the managed region and should only change while the block is idle.
// Sequence per mode (N = NUM_BLOCKS); the result is registered from the last state:
//   zero-size allocate, bad free address, unused mode: result registered from idle.
//   allocate: the divider gives the block count, ST_PRIME the first map read; then
//     map bits are scanned one a cycle until a run fits (up to N), which is then marked.
//   free: the divider gives the block index, ST_PRIME the first map read; then used
//     blocks are released in turn until a free block or the last block stops the walk.
//   clear: one map bit written per cycle across the whole map.
// The map memory has one read and one write port; the scan streams one bit a
// cycle through the registered read port, which sets the per-block rate.
// After reset the block sweeps the whole map to zero with busy high;
// the base register returns to 0x20001000 at once.
module first_fit_block_allocator #(
   parameter int NUM_BLOCKS  = 256,
   parameter int BLOCK_BYTES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_alloc_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_base_address
);

   localparam int IDX_W   = $clog2(NUM_BLOCKS);
   localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
   localparam int REG_W   = $clog2(NUM_BLOCKS * BLOCK_BYTES);
   localparam int DIV_W   = (REG_W > 17) ? REG_W : 17;
   localparam logic [31:0] REGION_BYTES = 32'(NUM_BLOCKS * BLOCK_BYTES);
   localparam logic [31:0] STEP_BYTES   = 32'(BLOCK_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

   ffba_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] start_idx_ff, start_idx_in;
   logic [CNT_W-1:0] run_ff, run_in;
   logic [DIV_W-1:0] need_ff, need_in;
   logic [31:0]      cur_addr_ff, cur_addr_in;
   logic [31:0]      start_addr_ff, start_addr_in;
   logic             is_alloc_ff, is_alloc_in;
   logic             init_ff, init_in;
   logic [31:0]      base_ff, base_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ffba_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_granted_ff, rsp_granted_in;

   logic             accept;
   logic [31:0]      offset;
   logic [CNT_W-1:0] run_plus;
   logic             rd_data;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic             wr_data;
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;

   assign busy      = (state_ff != ffba_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign offset    = req_free_address - base_ff;
   assign run_plus  = run_ff + CNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      start_idx_in   = start_idx_ff;
      run_in         = run_ff;
      need_in        = need_ff;
      cur_addr_in    = cur_addr_ff;
      start_addr_in  = start_addr_ff;
      is_alloc_in    = is_alloc_ff;
      init_in        = init_ff;
      base_in        = (csr_valid && csr_ready) ? csr_base_address : base_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rd_addr        = idx_ff + IDX_W'(1);
      wr_en          = 1'b0;
      wr_data        = 1'b0;
      div_start      = 1'b0;
      div_dividend   = DIV_W'(req_alloc_size) + DIV_W'(BLOCK_BYTES - 1);

      case (state_ff)
         ffba_pkg::ST_IDLE: begin
            if (accept) begin
               case (ffba_pkg::mode_type'(req_mode))
                  ffba_pkg::MODE_ALLOC: begin
                     if (req_alloc_size == 16'd0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = ffba_pkg::STAT_ZERO;
                        rsp_granted_in = '0;
                     end else begin
                        div_start   = 1'b1;
                        is_alloc_in = 1'b1;
                        state_in    = ffba_pkg::ST_DIVIDE;
                     end
                  end
                  ffba_pkg::MODE_FREE: begin
                     div_dividend = offset[DIV_W-1:0];
                     if (req_free_address == 32'd0 || offset >= REGION_BYTES) begin
                        rsp_valid_in   = 1'b1;
                        rsp_status_in  = ffba_pkg::STAT_BADADDR;
                        rsp_granted_in = '0;
                     end else begin
                        div_start   = 1'b1;
                        is_alloc_in = 1'b0;
                        state_in    = ffba_pkg::ST_DIVIDE;
                     end
                  end
                  ffba_pkg::MODE_CLEAR: begin
                     idx_in   = '0;
                     state_in = ffba_pkg::ST_CLEAR;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = ffba_pkg::STAT_OK;
                     rsp_granted_in = '0;
                  end
               endcase
            end
         end
         ffba_pkg::ST_DIVIDE: begin
            if (div_done) begin
               if (is_alloc_ff) begin
                  need_in     = div_quot;
                  idx_in      = '0;
                  run_in      = '0;
                  cur_addr_in = base_ff;
               end else begin
                  idx_in = div_quot[IDX_W-1:0];
               end
               state_in = ffba_pkg::ST_PRIME;
            end
         end
         ffba_pkg::ST_PRIME: begin
            // first read of the stream; later reads run one block ahead
            rd_addr  = idx_ff;
            state_in = is_alloc_ff ? ffba_pkg::ST_SCAN : ffba_pkg::ST_RELEASE;
         end
         ffba_pkg::ST_SCAN: begin
            if (!rd_data && DIV_W'(run_plus) == need_ff) begin
               idx_in        = (run_ff == '0) ? idx_ff : start_idx_ff;
               start_addr_in = (run_ff == '0) ? cur_addr_ff : start_addr_ff;
               run_in        = run_plus;
               state_in      = ffba_pkg::ST_MARK;
            end else begin
               if (!rd_data) begin
                  if (run_ff == '0) begin
                     start_idx_in  = idx_ff;
                     start_addr_in = cur_addr_ff;
                  end
                  run_in = run_plus;
               end else begin
                  run_in = '0;
               end
               if (idx_ff == LAST_IDX) begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ffba_pkg::STAT_NOSPACE;
                  rsp_granted_in = '0;
                  state_in       = ffba_pkg::ST_IDLE;
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  cur_addr_in = cur_addr_ff + STEP_BYTES;
               end
            end
         end
         ffba_pkg::ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
            idx_in  = idx_ff + IDX_W'(1);
            run_in  = run_ff - CNT_W'(1);
            if (run_ff == CNT_W'(1)) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffba_pkg::STAT_OK;
               rsp_granted_in = start_addr_ff;
               state_in       = ffba_pkg::ST_IDLE;
            end
         end
         ffba_pkg::ST_RELEASE: begin
            if (rd_data) begin
               wr_en = 1'b1;
            end
            if (!rd_data || idx_ff == LAST_IDX) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ffba_pkg::STAT_OK;
               rsp_granted_in = '0;
               state_in       = ffba_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ffba_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ffba_pkg::ST_IDLE;
               if (init_ff) begin
                  init_in = 1'b0;
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ffba_pkg::STAT_OK;
                  rsp_granted_in = '0;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ffba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::ST_CLEAR;
         idx_ff       <= '0;
         run_ff       <= '0;
         is_alloc_ff  <= 1'b0;
         init_ff      <= 1'b1;
         base_ff      <= ffba_pkg::BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         run_ff       <= run_in;
         is_alloc_ff  <= is_alloc_in;
         init_ff      <= init_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      start_idx_ff   <= start_idx_in;
      need_ff        <= need_in;
      cur_addr_ff    <= cur_addr_in;
      start_addr_ff  <= start_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
   end

   ffba_map_ram #(
      .DEPTH (NUM_BLOCKS),
      .AW    (IDX_W)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ffba_div #(
      .BLOCK_BYTES (BLOCK_BYTES),
      .DIV_W       (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_granted_ff;

endmodule

// ===== rtl/ffba_map_ram.sv =====
// Used-block map: one-bit memory, one write port and one registered read port.
module ffba_map_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic map_ff [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ffba_div.sv =====
// Division by the constant block size through a reciprocal multiply; the dividend and the quotient are registered.
module ffba_div #(
   parameter int BLOCK_BYTES = 16,
   parameter int DIV_W       = 17
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   // q = (x * ceil(2^SH / d)) >> SH is exact for every x below 2^DIV_W
   localparam int SH = DIV_W + $clog2(BLOCK_BYTES);
   localparam int MW = DIV_W + 2;
   localparam int PW = DIV_W + MW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
   localparam logic [MW-1:0] RECIP_W = MW'(RECIP);

   logic [DIV_W-1:0] dvd_ff, dvd_in;
   logic [DIV_W-1:0] quot_ff, quot_in;
   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [PW-1:0]    product;

   always_comb begin
      product   = PW'(dvd_ff) * PW'(RECIP_W);
      dvd_in    = start ? dividend : dvd_ff;
      quot_in   = active_ff ? DIV_W'(product >> SH) : quot_ff;
      active_in = start;
      done_in   = active_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule
